// ----- rtl/kpt_pkg.sv -----
// Package for the keyed pair table: capacity, field widths, request and
// result codes, and the command/status bundles between controller and datapath.
// No dependencies.
package kpt_pkg;

  // Table capacity and derived index widths
  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = 5;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned ValW     = 32;

  // Stream payload widths
  localparam int unsigned InDataW  = KeyW + ValW;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 8;

  // Request kinds
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_ERASE  = 2'd1,
    MODE_QKEY   = 2'd2,
    MODE_QVAL   = 2'd3
  } kpt_mode_e;

  // Result codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } kpt_status_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // latch a new request, restart the scan
    logic step;      // compare one entry, advance the scan
    logic sel_last;  // point the read port at the last entry
    logic commit;    // apply the request and load the result
  } kpt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic at_end;    // scan has passed the last stored entry
    logic hit;       // current entry matches
    logic out_free;  // result register can take a new result
  } kpt_stat_t;

endpackage

// ----- rtl/kpt_ctrl.sv -----
// Controller of the keyed pair table: a one-hot state machine that runs
// accept, scan and commit. Depends on kpt_pkg.
module kpt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kpt_pkg::kpt_stat_t stat_i,
  output kpt_pkg::kpt_cmd_t  cmd_o
);
  import kpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (stat_i.at_end || stat_i.hit) begin
          // aim the read port at the last entry ahead of the commit
          cmd_o.sel_last = 1'b1;
          state_d        = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.sel_last = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/kpt_datapath.sv -----
// Datapath of the keyed pair table: request registers, key and value
// register files, scan index, entry count and result register. Depends on kpt_pkg.
module kpt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [kpt_pkg::InDataW-1:0]   in_data_i,
  input  logic [kpt_pkg::InUserW-1:0]   in_user_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kpt_pkg::OutDataW-1:0]  out_data_o,
  input  kpt_pkg::kpt_cmd_t             cmd_i,
  output kpt_pkg::kpt_stat_t            stat_o
);
  import kpt_pkg::*;

  // Register files, undefined until written
  logic [KeyW-1:0] key_mem [Capacity];
  logic [ValW-1:0] val_mem [Capacity];

  kpt_mode_e       mode_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] slot_q;
  logic            found_q;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  kpt_status_e     status_q, status_d;
  logic [CntW-1:0] out_count_q;
  logic [KeyW-1:0] rd_key_q;
  logic [ValW-1:0] rd_val_q;

  logic [CntW-1:0] last_cnt;
  logic [IdxW-1:0] rd_idx;
  logic            at_end;
  logic            hit;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [KeyW-1:0] wr_key;
  logic [ValW-1:0] wr_val;

  // Next scan index
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.step && !at_end && !hit) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  // Single read port, addressed one step ahead so the read register holds
  // the entry at the scan index, or the last entry during commit
  assign last_cnt = count_q - CntW'(1);
  assign rd_idx   = cmd_i.sel_last ? last_cnt[IdxW-1:0] : idx_d[IdxW-1:0];

  // Compare the current entry
  assign at_end = (idx_q >= count_q);
  assign hit    = !at_end &&
                  ((mode_q == MODE_QVAL) ? (rd_val_q == val_q) : (rd_key_q == key_q));

  assign stat_o.at_end   = at_end;
  assign stat_o.hit      = hit;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Decide the result and the table update
  always_comb begin
    status_d = ST_MISS;
    count_d  = count_q;
    wr_en    = 1'b0;
    wr_idx   = count_q[IdxW-1:0];
    wr_key   = key_q;
    wr_val   = val_q;
    case (mode_q)
      MODE_INSERT: begin
        if (found_q) begin
          status_d = ST_DUP;
        end else if (count_q >= CntW'(Capacity)) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          wr_en    = 1'b1;
          count_d  = count_q + CntW'(1);
        end
      end
      MODE_ERASE: begin
        if (found_q) begin
          // move the last entry into the freed slot
          status_d = ST_OK;
          wr_en    = 1'b1;
          wr_idx   = slot_q;
          wr_key   = rd_key_q;
          wr_val   = rd_val_q;
          count_d  = last_cnt;
        end
      end
      default: begin
        status_d = found_q ? ST_OK : ST_MISS;
      end
    endcase
  end

  // Request payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= kpt_mode_e'(in_user_i);
      key_q  <= in_data_i[KeyW-1:0];
      val_q  <= in_data_i[KeyW +: ValW];
    end
    if (cmd_i.step && hit) begin
      slot_q <= idx_q[IdxW-1:0];
    end
    if (cmd_i.commit) begin
      status_q    <= status_d;
      out_count_q <= count_d;
    end
  end

  // Register file writes and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      key_mem[wr_idx] <= wr_key;
      val_mem[wr_idx] <= wr_val;
    end
    rd_key_q <= key_mem[rd_idx];
    rd_val_q <= val_mem[rd_idx];
  end

  // Scan control, count and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      found_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (cmd_i.step && hit) begin
        found_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {1'b0, out_count_q, status_q};

endmodule

// ----- rtl/keyed_pair_table.sv -----
// Keyed pair table: unordered key/value store of 16 entries, linear scan.
// Each accepted item is scanned one stored entry at a time until a match or
// the end of the stored entries, then committed to the result register.
// The next item is taken while the result still waits; its own commit then
// waits for the result register. Reset clears the count and handshake
// state at once; stored entries are not cleared and are never read unwritten.
module keyed_pair_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [kpt_pkg::InDataW-1:0]   s_axis_tdata_i,   // key, value
  input  logic [kpt_pkg::InUserW-1:0]   s_axis_tuser_i,   // mode
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [kpt_pkg::OutDataW-1:0]  m_axis_tdata_o    // status, count, pad
);
  import kpt_pkg::*;

  kpt_cmd_t  cmd;
  kpt_stat_t stat;

  // Sequencer
  kpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage, compare and result register
  kpt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ----- dv/keyed_pair_table_tb.sv -----
`timescale 1ns / 1ps
// Testbench for keyed_pair_table: directed requests on an empty and a full
// table, then weighted random requests checked against a behavioral store.
// Depends on kpt_pkg and keyed_pair_table.
module keyed_pair_table_tb;
  import kpt_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomPhases  = 12;
  localparam int unsigned PhaseItems    = 100;
  localparam int unsigned NumRows       = 16;
  localparam int unsigned FillAt        = 10;  // rows from here on start from a full table
  localparam int unsigned HoldCycles    = 500;
  localparam int unsigned TailCycles    = 40;

  typedef struct packed {
    kpt_status_e     status;
    logic [CntW-1:0] count;
  } kpt_result_t;

  typedef struct packed {
    kpt_mode_e       mode;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic            typed;
    kpt_result_t     result;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_data = '0;
  logic [InUserW-1:0]  s_user = '0;
  logic                s_ready;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;

  // Behavioral copy of the store
  logic [KeyW-1:0] model_keys [Capacity];
  logic [ValW-1:0] model_vals [Capacity];
  int unsigned     model_cnt = 0;

  kpt_result_t pending_results [$];
  dir_row_t    dir_rows [NumRows];
  logic [KeyW-1:0] key_pool [8];
  logic [ValW-1:0] val_pool [8];

  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  logic long_hold_done = 1'b0;

  keyed_pair_table dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // key, value
    .s_axis_tuser_i  (s_user),   // mode
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)    // status, count, pad
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the store copy and return the result it gives
  function automatic kpt_result_t apply_to_store(kpt_mode_e mode, logic [KeyW-1:0] key,
                                                 logic [ValW-1:0] value);
    kpt_result_t res;
    int slot;
    res.status = ST_MISS;
    slot = -1;
    for (int i = 0; i < model_cnt; i++) begin
      if (slot < 0 && model_keys[i] == key) slot = i;
    end
    case (mode)
      MODE_INSERT: begin
        if (slot >= 0) begin
          res.status = ST_DUP;
        end else if (model_cnt >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          model_keys[model_cnt] = key;
          model_vals[model_cnt] = value;
          model_cnt++;
          res.status = ST_OK;
        end
      end
      MODE_ERASE: begin
        // move the last pair into the freed slot
        if (slot >= 0) begin
          model_keys[slot] = model_keys[model_cnt-1];
          model_vals[slot] = model_vals[model_cnt-1];
          model_cnt--;
          res.status = ST_OK;
        end
      end
      MODE_QKEY: begin
        if (slot >= 0) res.status = ST_OK;
      end
      default: begin
        for (int i = 0; i < model_cnt; i++) begin
          if (model_vals[i] == value) res.status = ST_OK;
        end
      end
    endcase
    res.count = CntW'(model_cnt);
    return res;
  endfunction

  // Offer one item, hold it until taken, then queue its expected result
  task automatic send_request(input kpt_mode_e mode, input logic [KeyW-1:0] key,
                              input logic [ValW-1:0] value, input logic typed,
                              input kpt_result_t typed_result);
    kpt_result_t predicted;
    s_valid <= 1'b1;
    s_data  <= {value, key};
    s_user  <= mode;
    do @(posedge clk); while (!s_ready);
    predicted = apply_to_store(mode, key, value);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // Random gap after an item: mostly none, a few long
  task automatic sender_gap();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 60) len = 0;
    else if (r < 90) len = $urandom_range(1, 3);
    else if (r < 98) len = $urandom_range(4, 12);
    else len = $urandom_range(30, 80);
    if (len != 0) begin
      s_valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // Stop offering and hold until every result is back
  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Stimulus
  initial begin
    kpt_mode_e       mode;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    int              r;
    int              pick;
    int              hit_pct;

    dir_rows[0]  = '{MODE_QKEY,   32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_MISS, 5'd0}};
    dir_rows[1]  = '{MODE_ERASE,  32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_MISS, 5'd0}};
    dir_rows[2]  = '{MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OK,   5'd1}};
    dir_rows[3]  = '{MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK,   5'd2}};
    dir_rows[4]  = '{MODE_INSERT, 32'h0000_0000, 32'h5A5A_5A5A, 1'b1, '{ST_DUP,  5'd2}};
    dir_rows[5]  = '{MODE_QKEY,   32'hFFFF_FFFF, 32'h1234_5678, 1'b1, '{ST_OK,   5'd2}};
    dir_rows[6]  = '{MODE_QVAL,   32'h0000_0000, 32'h5A5A_5A5A, 1'b1, '{ST_MISS, 5'd2}};
    dir_rows[7]  = '{MODE_ERASE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_OK,   5'd1}};
    dir_rows[8]  = '{MODE_QKEY,   32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_MISS, 5'd1}};
    dir_rows[9]  = '{MODE_ERASE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_OK,   5'd0}};
    dir_rows[10] = '{MODE_INSERT, 32'h1234_5678, 32'h8765_4321, 1'b1, '{ST_FULL, 5'd16}};
    dir_rows[11] = '{MODE_INSERT, 32'h0F0F_0003, 32'h0000_0000, 1'b1, '{ST_DUP,  5'd16}};
    dir_rows[12] = '{MODE_QVAL,   32'h0000_0000, 32'hC000_000F, 1'b1, '{ST_OK,   5'd16}};
    dir_rows[13] = '{MODE_ERASE,  32'h0F0F_0003, 32'h0000_0000, 1'b1, '{ST_OK,   5'd15}};
    dir_rows[14] = '{MODE_QVAL,   32'h0000_0000, 32'hC000_0003, 1'b1, '{ST_MISS, 5'd15}};
    dir_rows[15] = '{MODE_QKEY,   32'h0F0F_000F, 32'h0000_0000, 1'b1, '{ST_OK,   5'd15}};

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h0000_0001;
    val_pool[0] = 32'h0000_0000;
    val_pool[1] = 32'hFFFF_FFFF;
    val_pool[2] = 32'h7FFF_FFFF;
    val_pool[3] = 32'h0000_0001;
    for (int i = 4; i < 8; i++) begin
      key_pool[i] = $urandom;
      val_pool[i] = $urandom;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; fill the table just before the full-table rows
    for (int i = 0; i < NumRows; i++) begin
      if (i == FillAt) begin
        for (int j = 0; j < Capacity; j++) begin
          send_request(MODE_INSERT, 32'h0F0F_0000 + j, 32'hC000_0000 + j, 1'b0, '0);
          sender_gap();
        end
      end
      send_request(dir_rows[i].mode, dir_rows[i].key, dir_rows[i].value,
                   dir_rows[i].typed, dir_rows[i].result);
      sender_gap();
    end
    wait_drained();

    // Random phases that swing the table between empty and full
    for (int ph = 0; ph < RandomPhases; ph++) begin
      for (int n = 0; n < PhaseItems; n++) begin
        r = $urandom_range(0, 99);
        case (ph % 3)
          0: mode = (r < 60) ? MODE_INSERT : (r < 70) ? MODE_ERASE :
                    (r < 85) ? MODE_QKEY : MODE_QVAL;
          1: mode = (r < 20) ? MODE_INSERT : (r < 65) ? MODE_ERASE :
                    (r < 85) ? MODE_QKEY : MODE_QVAL;
          default: mode = kpt_mode_e'(r % 4);
        endcase
        hit_pct = (mode == MODE_INSERT) ? 20 : 55;
        pick = $urandom_range(0, 99);
        if (model_cnt != 0 && pick < hit_pct) key = model_keys[$urandom_range(0, model_cnt-1)];
        else if (pick < 85) key = key_pool[$urandom_range(0, 7)];
        else key = $urandom;
        pick = $urandom_range(0, 99);
        if (mode == MODE_QVAL && model_cnt != 0 && pick < 50) begin
          value = model_vals[$urandom_range(0, model_cnt-1)];
        end else if (pick < 70) begin
          value = val_pool[$urandom_range(0, 7)];
        end else begin
          value = $urandom;
        end
        send_request(mode, key, value, 1'b0, '0);
        sender_gap();
      end
      if (ph % 4 == 3) wait_drained();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side back-pressure, with one long hold-off once results flow
  initial begin
    int r;
    int len;
    forever begin
      if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        repeat (HoldCycles) begin
          m_ready <= 1'b0;
          @(posedge clk);
        end
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        len = $urandom_range(1, 30);
        repeat (len) begin
          m_ready <= 1'b1;
          @(posedge clk);
        end
      end else if (r < 85) begin
        len = $urandom_range(1, 20);
        repeat (len) begin
          m_ready <= ($urandom_range(0, 99) < 65);
          @(posedge clk);
        end
      end else begin
        len = $urandom_range(20, 80);
        repeat (len) begin
          m_ready <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin : check_results
    kpt_result_t got;
    kpt_result_t want;
    if (rst_n && m_valid && m_ready) begin
      got.status = kpt_status_e'(m_data[1:0]);
      got.count  = m_data[2 +: CntW];
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: status %0d count %0d", got.status, got.count);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.count !== want.count) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: status exp %0d got %0d, count exp %0d got %0d",
                     want.status, got.status, want.count, got.count);
          end
        end
      end
    end
  end

  // End the run if no item moves on either side for too long
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
